>>> rtl/core/dss_pkg.sv
// Shared types and codes for the dual-stack block.
package dss_pkg;

    localparam int unsigned DssDepthDefault = 16;

    localparam int unsigned KindW   = 2;
    localparam int unsigned StatusW = 2;
    localparam int unsigned WordW   = 32;

    localparam logic [KindW-1:0] KIND_PUSH = 2'd0;
    localparam logic [KindW-1:0] KIND_POP  = 2'd1;
    localparam logic [KindW-1:0] KIND_PEEK = 2'd2;

    localparam logic [StatusW-1:0] ST_OK        = 2'd0;
    localparam logic [StatusW-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [StatusW-1:0] ST_UNDERFLOW = 2'd2;

    typedef struct packed {
        logic load_op;
        logic exec;
        logic load_out;
    } t_dp_cmd;

endpackage

>>> rtl/core/dss_datapath.sv
// Datapath: stack pointers, shared word memory and result register.
module dss_datapath #(
    parameter int unsigned STORE_DEPTH = dss_pkg::DssDepthDefault
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  dss_pkg::t_dp_cmd            i_cmd,
    input  logic [dss_pkg::KindW-1:0]   i_kind,
    input  logic                        i_which_stack,
    input  logic [dss_pkg::WordW-1:0]   i_push_value,
    output logic [dss_pkg::StatusW-1:0] o_status,
    output logic [dss_pkg::WordW-1:0]   o_top_value
);
    import dss_pkg::*;

    localparam int unsigned CW = $clog2(STORE_DEPTH + 1);
    localparam int unsigned IW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);
    localparam logic [CW:0]   DEPTH_W = (CW + 1)'(STORE_DEPTH);

    logic [WordW-1:0] r_mem [STORE_DEPTH];

    logic [KindW-1:0]   r_kind;
    logic               r_which;
    logic [WordW-1:0]   r_word;
    logic [CW-1:0]      r_lower;
    logic [CW-1:0]      r_upper;
    logic [CW-1:0]      n_lower;
    logic [CW-1:0]      n_upper;
    logic [StatusW-1:0] r_res_status;
    logic [StatusW-1:0] n_res_status;
    logic               r_res_read;
    logic               n_res_read;
    logic [WordW-1:0]   r_rdata;
    logic [StatusW-1:0] r_out_status;
    logic [WordW-1:0]   r_out_value;

    logic [CW:0]   used;
    logic          full;
    logic          empty;
    logic          do_write;
    logic [CW-1:0] addr_full;
    logic [IW-1:0] addr;

    assign used  = {1'b0, r_lower} + {1'b0, r_upper};
    assign full  = (used >= DEPTH_W);
    assign empty = r_which ? (r_upper == '0) : (r_lower == '0);

    always_comb begin
        n_lower      = r_lower;
        n_upper      = r_upper;
        n_res_status = ST_OK;
        n_res_read   = 1'b0;
        do_write     = 1'b0;
        addr_full    = r_which ? (DEPTH_C - r_upper) : (r_lower - CW'(1));
        unique case (r_kind)
            KIND_PUSH: begin
                addr_full = r_which ? (DEPTH_C - r_upper - CW'(1)) : r_lower;
                if (full) begin
                    n_res_status = ST_OVERFLOW;
                end else begin
                    do_write = 1'b1;
                    if (r_which) n_upper = r_upper + CW'(1);
                    else         n_lower = r_lower + CW'(1);
                end
            end
            KIND_POP, KIND_PEEK: begin
                if (empty) begin
                    n_res_status = ST_UNDERFLOW;
                end else begin
                    n_res_read = 1'b1;
                    if (r_kind == KIND_POP) begin
                        if (r_which) n_upper = r_upper - CW'(1);
                        else         n_lower = r_lower - CW'(1);
                    end
                end
            end
            default: begin
            end
        endcase
        addr = addr_full[IW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            if (do_write) r_mem[addr] <= r_word;
            r_rdata <= r_mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower <= '0;
            r_upper <= '0;
        end else if (i_cmd.exec) begin
            r_lower <= n_lower;
            r_upper <= n_upper;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_op) begin
            r_kind  <= i_kind;
            r_which <= i_which_stack;
            r_word  <= i_push_value;
        end
        if (i_cmd.exec) begin
            r_res_status <= n_res_status;
            r_res_read   <= n_res_read;
        end
        if (i_cmd.load_out) begin
            r_out_status <= r_res_status;
            r_out_value  <= r_res_read ? r_rdata : '0;
        end
    end

    assign o_status    = r_out_status;
    assign o_top_value = r_out_value;

endmodule

>>> rtl/core/dss_ctrl.sv
// Controller: sequences accept, execute and result hand-off.
module dss_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output dss_pkg::t_dp_cmd o_cmd
);
    import dss_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_RESP = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_s_tready   = 1'b0;
        n_out_valid  = r_out_valid && !i_m_tready;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready    = 1'b1;
                o_cmd.load_op = i_s_tvalid;
                if (i_s_tvalid) n_state = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_RESP;
            end
            S_RESP: begin
                if (!r_out_valid || i_m_tready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;

endmodule

>>> rtl/core/dual_stack_shared_array_top.sv
// Two stacks sharing one word memory: top level.
// Each transaction asks for a push, pop or peek on the lower (growing up) or
// upper (growing down) stack and yields one result with a status code and,
// for a successful pop or peek, the top word. An operation passes from
// acceptance to result through capture, one memory access with registered
// read data, and load of the output register (held off while an earlier
// result waits downstream); the next transaction is accepted in the cycle
// after the result is loaded, while that result may still wait for the
// downstream side. No clearing pass is needed after reset.
module dual_stack_shared_array_top #(
    parameter int unsigned STORE_DEPTH = dss_pkg::DssDepthDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] push_value
    input  logic [2:0]  s_axis_tuser,   // [1:0] kind, [2] which_stack
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] top_value
    output logic [1:0]  m_axis_tuser    // [1:0] status
);
    import dss_pkg::*;

    t_dp_cmd cmd;

    dss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_cmd      (cmd)
    );

    dss_datapath #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_kind        (s_axis_tuser[1:0]),
        .i_which_stack (s_axis_tuser[2]),
        .i_push_value  (s_axis_tdata),
        .o_status      (m_axis_tuser),
        .o_top_value   (m_axis_tdata)
    );

endmodule

>>> rtl/core/dss_checker.sv
// Port-level checker for the dual-stack block, bound to the top level.
module dss_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);
    import dss_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == ST_OK || m_axis_tuser == ST_OVERFLOW
                           || m_axis_tuser == ST_UNDERFLOW))
        else $error("bad status code");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tdata == '0)
        else $error("failed operation returned data");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready ##1 !s_axis_tready)
        else $error("transaction accepted while busy");

endmodule

bind dual_stack_shared_array_top dss_checker u_dss_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

>>> tb/tb_dual_stack_shared_array_top.sv
// Self-checking testbench for the two stacks sharing one word memory.
`timescale 1ns / 1ps

module tb_dual_stack_shared_array_top;
    import dss_pkg::*;

    localparam int unsigned DEPTH        = DssDepthDefault;
    localparam int unsigned RANDOM_ITEMS = 600;
    localparam int unsigned LIMIT_CYCLES = 200000;
    localparam int unsigned HOLD_CYCLES  = 150;
    localparam int unsigned SETTLE       = 8;
    localparam int unsigned DIR_ROWS     = 23;
    localparam logic [KindW-1:0] KIND_SPARE = 2'd3;

    typedef struct packed {
        logic [StatusW-1:0] status;
        logic [WordW-1:0]   value;
    } stack_result_t;

    typedef struct packed {
        logic [KindW-1:0]   kind;
        logic               upper;
        logic [WordW-1:0]   word;
        int unsigned        reps;
        bit                 typed;
        logic [StatusW-1:0] status;
        logic [WordW-1:0]   value;
    } dir_row_t;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;   // [31:0] push_value
    logic [2:0]  s_axis_tuser  = '0;   // [1:0] kind, [2] which_stack
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // [31:0] top_value
    logic [1:0]  m_axis_tuser;         // [1:0] status

    logic [WordW-1:0] shadow_words [DEPTH];
    int unsigned      lower_used = 0;
    int unsigned      upper_used = 0;
    stack_result_t    awaited_results [$];
    int unsigned      mismatch_count = 0;
    int unsigned      cycle_count = 0;
    bit               hold_request = 1'b0;
    bit               send_eager = 1'b0;
    int unsigned      send_left = 0;
    bit               recv_eager = 1'b0;
    int unsigned      recv_left = 0;

    dir_row_t directed_plan [DIR_ROWS] = '{
        '{KIND_POP,   1'b0, 32'h0000_0000, 1, 1'b1, ST_UNDERFLOW, 32'h0000_0000},
        '{KIND_PEEK,  1'b0, 32'h0000_0000, 1, 1'b1, ST_UNDERFLOW, 32'h0000_0000},
        '{KIND_POP,   1'b1, 32'h0000_0000, 1, 1'b1, ST_UNDERFLOW, 32'h0000_0000},
        '{KIND_PEEK,  1'b1, 32'h0000_0000, 1, 1'b1, ST_UNDERFLOW, 32'h0000_0000},
        '{KIND_SPARE, 1'b0, 32'hFFFF_FFFF, 1, 1'b1, ST_OK,        32'h0000_0000},
        '{KIND_PUSH,  1'b0, 32'h7FFF_FFFF, 1, 1'b1, ST_OK,        32'h0000_0000},
        '{KIND_PUSH,  1'b1, 32'h8000_0000, 1, 1'b1, ST_OK,        32'h0000_0000},
        '{KIND_PEEK,  1'b0, 32'h0000_0000, 1, 1'b1, ST_OK,        32'h7FFF_FFFF},
        '{KIND_PEEK,  1'b1, 32'hFFFF_FFFF, 1, 1'b1, ST_OK,        32'h8000_0000},
        '{KIND_POP,   1'b0, 32'h0000_0000, 1, 1'b1, ST_OK,        32'h7FFF_FFFF},
        '{KIND_POP,   1'b0, 32'h0000_0000, 1, 1'b1, ST_UNDERFLOW, 32'h0000_0000},
        '{KIND_PUSH,  1'b0, 32'hFFFF_FFFF, 1, 1'b1, ST_OK,        32'h0000_0000},
        '{KIND_PUSH,  1'b1, 32'h0000_0000, 1, 1'b1, ST_OK,        32'h0000_0000},
        '{KIND_SPARE, 1'b1, 32'h5A5A_A5A5, 1, 1'b1, ST_OK,        32'h0000_0000},
        '{KIND_PUSH,  1'b1, 32'h1000_0000, 6, 1'b1, ST_OK,        32'h0000_0000},
        '{KIND_PUSH,  1'b0, 32'h2000_0000, 7, 1'b1, ST_OK,        32'h0000_0000},
        '{KIND_PUSH,  1'b0, 32'h3333_3333, 1, 1'b1, ST_OVERFLOW,  32'h0000_0000},
        '{KIND_PUSH,  1'b1, 32'hCCCC_CCCC, 1, 1'b1, ST_OVERFLOW,  32'h0000_0000},
        '{KIND_PEEK,  1'b1, 32'h0000_0000, 1, 1'b0, ST_OK,        32'h0000_0000},
        '{KIND_POP,   1'b0, 32'h0000_0000, 8, 1'b0, ST_OK,        32'h0000_0000},
        '{KIND_PEEK,  1'b0, 32'h0000_0000, 1, 1'b1, ST_UNDERFLOW, 32'h0000_0000},
        '{KIND_POP,   1'b1, 32'h0000_0000, 8, 1'b0, ST_OK,        32'h0000_0000},
        '{KIND_POP,   1'b1, 32'h0000_0000, 1, 1'b1, ST_UNDERFLOW, 32'h0000_0000}
    };

    dual_stack_shared_array_top #(
        .STORE_DEPTH(DEPTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("dual_stack_shared_array_top test failed");
            $finish;
        end
    end

    function automatic int unsigned next_wait(inout bit eager, inout int unsigned left);
        if (left == 0) begin
            eager = ($urandom_range(0, 2) == 0);
            left  = $urandom_range(8, 40);
        end
        left--;
        return eager ? 0 : $urandom_range(0, 13);
    endfunction

    function automatic stack_result_t stack_outcome(input logic [KindW-1:0] kind,
                                                    input logic upper,
                                                    input logic [WordW-1:0] word);
        stack_result_t res;
        int unsigned   depth;
        res.status = ST_OK;
        res.value  = '0;
        depth = upper ? upper_used : lower_used;
        case (kind)
            KIND_PUSH: begin
                if (lower_used + upper_used >= DEPTH) begin
                    res.status = ST_OVERFLOW;
                end else if (upper) begin
                    upper_used++;
                    shadow_words[DEPTH - upper_used] = word;
                end else begin
                    shadow_words[lower_used] = word;
                    lower_used++;
                end
            end
            KIND_POP, KIND_PEEK: begin
                if (depth == 0) begin
                    res.status = ST_UNDERFLOW;
                end else begin
                    res.value = upper ? shadow_words[DEPTH - upper_used]
                                      : shadow_words[lower_used - 1];
                    if (kind == KIND_POP) begin
                        if (upper) upper_used--;
                        else lower_used--;
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic send_item(input logic [KindW-1:0] kind, input logic upper,
                             input logic [WordW-1:0] word, input bit typed,
                             input logic [StatusW-1:0] status, input logic [WordW-1:0] value);
        int unsigned   gap;
        stack_result_t outcome;
        gap = next_wait(send_eager, send_left);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= {upper, kind};
        @(negedge i_clk);
        while (!s_axis_tready) @(negedge i_clk);
        @(posedge i_clk);
        outcome = stack_outcome(kind, upper, word);
        if (typed) begin
            outcome.status = status;
            outcome.value  = value;
        end
        awaited_results.push_back(outcome);
    endtask

    task automatic wait_drained();
        while (awaited_results.size() != 0) @(posedge i_clk);
    endtask

    initial begin : receive_side
        int unsigned   stall;
        stack_result_t got;
        stack_result_t want;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_request) begin
                stall = HOLD_CYCLES;
                hold_request = 1'b0;
            end else begin
                stall = next_wait(recv_eager, recv_left);
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(negedge i_clk);
            while (!m_axis_tvalid) @(negedge i_clk);
            got.status = m_axis_tuser;
            got.value  = m_axis_tdata;
            @(posedge i_clk);
            if (awaited_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: status %0d value %h", got.status, got.value);
            end else begin
                want = awaited_results.pop_front();
                if (got.status !== want.status || got.value !== want.value) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: status %0d value %h, expected status %0d value %h",
                                 got.status, got.value, want.status, want.value);
                end
            end
        end
    end

    initial begin : send_side
        int unsigned      issued;
        int unsigned      real_sent;
        int unsigned      mix;
        int unsigned      roll;
        int unsigned      push_pct;
        logic [KindW-1:0] kind;
        logic             upper;
        logic [WordW-1:0] word;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_plan[r]) begin
            for (int unsigned k = 0; k < directed_plan[r].reps; k++) begin
                send_item(directed_plan[r].kind, directed_plan[r].upper,
                          directed_plan[r].word + k, directed_plan[r].typed,
                          directed_plan[r].status, directed_plan[r].value);
            end
        end

        issued    = 0;
        real_sent = 0;
        mix       = 0;
        while (real_sent < RANDOM_ITEMS) begin
            if (issued % 60 == 0) mix = $urandom_range(0, 2);
            if (issued == 120 || issued == 450) begin
                s_axis_tvalid <= 1'b0;
                wait_drained();
            end
            if (issued == 250) begin
                hold_request = 1'b1;
                send_eager   = 1'b1;
                send_left    = 40;
            end
            push_pct = (mix == 0) ? 70 : (mix == 1) ? 25 : 45;
            roll = $urandom_range(0, 99);
            if (roll < 3) kind = KIND_SPARE;
            else if (roll < 3 + push_pct) kind = KIND_PUSH;
            else if ($urandom_range(0, 9) < 6) kind = KIND_POP;
            else kind = KIND_PEEK;
            upper = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 7))
                0: word = 32'h0000_0000;
                1: word = 32'h7FFF_FFFF;
                2: word = 32'h8000_0000;
                3: word = 32'hFFFF_FFFF;
                default: word = $urandom;
            endcase
            send_item(kind, upper, word, 1'b0, ST_OK, '0);
            issued++;
            if (kind != KIND_SPARE) real_sent++;
        end

        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        if (mismatch_count == 0 && awaited_results.size() == 0) begin
            $display("dual_stack_shared_array_top test passed");
        end else begin
            $display("dual_stack_shared_array_top test failed");
        end
        $finish;
    end

endmodule
